// ----- hw/rtl/uuencode_line_encoder_unit_macros.svh -----
// Assertion macros for the uuencode line encoder
`ifndef UUENCODE_LINE_ENCODER_UNIT_MACROS_SVH
`define UUENCODE_LINE_ENCODER_UNIT_MACROS_SVH

// same-cycle implication
`define UULE_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define UULE_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/uule_pkg.sv -----
// Package: constants, types and state codes of the uuencode line encoder
`timescale 1ns / 1ps
package uule_pkg;

    localparam int LINE_BYTES = 45;
    localparam int CNT_W      = $clog2(LINE_BYTES + 1);
    localparam int ADDR_W     = $clog2(LINE_BYTES);

    localparam logic [7:0] CHAR_OFFSET_RST = 8'd32;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LEN,
        S_RD,
        S_CAP,
        S_CHR,
        S_TERM
    } t_state;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic [ADDR_W-1:0] raddr;
    } t_buf_req;

    typedef struct packed {
        logic [7:0] out_char;
        logic       end_of_line;
        logic       last_of_run;
    } t_out_item;

endpackage

// ----- hw/rtl/uuencode_line_encoder_unit.sv -----
// Top level of the uuencode line encoder
//
//  channel   dir  handshake                        payload
//  s_axis    in   s_axis_tvalid / s_axis_tready    tdata = data_byte, tlast = end_of_data
//  m_axis    out  m_axis_tvalid / m_axis_tready    tdata = out_char, tlast = end_of_line,
//                                                  tuser = last_of_run
//  cfg       in   i_cfg_we                         i_cfg_wdata = char_offset
//
// A byte that does not close a line is written to the line buffer and the input stays ready.
// A byte that closes a line holds the input while the length char goes out, each byte
// is read from the buffer and captured, and the chars of each group go out, then the
// terminator line if a full line ends the data; each char uses the one extract/offset unit.
// A stalled output holds the sequencer in place; the output register lets the next
// item in while the final char of a line waits.
// Synchronous reset clears the line count and sets char_offset to 32.
`timescale 1ns / 1ps
module uuencode_line_encoder_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_char
    output logic       m_axis_tlast,
    output logic [0:0] m_axis_tuser    // [0] last_of_run
);

    uule_pkg::t_buf_req  buf_req;
    logic [7:0]          buf_rdata;
    uule_pkg::t_out_item out_item;

    uule_linebuf u_linebuf (
        .i_clk   (i_clk),
        .i_req   (buf_req),
        .o_rdata (buf_rdata)
    );

    uule_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_in_byte   (s_axis_tdata),
        .i_in_last   (s_axis_tlast),
        .o_buf_req   (buf_req),
        .i_buf_rdata (buf_rdata),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_item  (out_item)
    );

    assign m_axis_tdata    = out_item.out_char;
    assign m_axis_tlast    = out_item.end_of_line;
    assign m_axis_tuser[0] = out_item.last_of_run;

endmodule

// ----- hw/rtl/uule_linebuf.sv -----
// Line buffer: one write port, one registered read port
`timescale 1ns / 1ps
module uule_linebuf (
    input  logic               i_clk,
    input  uule_pkg::t_buf_req i_req,
    output logic [7:0]         o_rdata
);

    logic [7:0] r_mem [uule_pkg::LINE_BYTES];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/uule_seq.sv -----
// Sequencer: byte intake, group assembly, shared 6-bit extract/offset unit, output register
`timescale 1ns / 1ps
module uule_seq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [7:0]           i_cfg_wdata,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [7:0]           i_in_byte,
    input  logic                 i_in_last,
    output uule_pkg::t_buf_req   o_buf_req,
    input  logic [7:0]           i_buf_rdata,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output uule_pkg::t_out_item  o_out_item
);

    localparam int CW = uule_pkg::CNT_W;

    uule_pkg::t_state    r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_len, n_len;
    logic [CW-1:0]       r_pos, n_pos;
    logic                r_term, n_term;
    logic [1:0]          r_k, n_k;
    logic [1:0]          r_c, n_c;
    logic [23:0]         r_word, n_word;
    logic [7:0]          r_offset;
    logic                r_ovalid, n_ovalid;
    uule_pkg::t_out_item r_out, n_out;

    logic          out_free;
    logic [CW-1:0] cnt_inc;
    logic          full;
    logic [CW-1:0] rem;
    logic [1:0]    grp_n;
    logic          grp_end;
    logic          line_end;
    logic [CW-1:0] pos_next;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= uule_pkg::S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
            r_offset <= uule_pkg::CHAR_OFFSET_RST;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                r_offset <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_len  <= n_len;
        r_pos  <= n_pos;
        r_term <= n_term;
        r_k    <= n_k;
        r_c    <= n_c;
        r_word <= n_word;
        r_out  <= n_out;
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_len    = r_len;
        n_pos    = r_pos;
        n_term   = r_term;
        n_k      = r_k;
        n_c      = r_c;
        n_word   = r_word;
        n_out    = r_out;
        out_free = !r_ovalid || i_out_ready;
        n_ovalid = r_ovalid && !i_out_ready;

        cnt_inc  = CW'(r_count + CW'(1));
        full     = (cnt_inc == CW'(uule_pkg::LINE_BYTES));
        rem      = CW'(r_len - r_pos);
        grp_n    = (rem > CW'(3)) ? 2'd3 : rem[1:0];
        pos_next = CW'(r_pos + CW'(grp_n));
        grp_end  = (r_c == grp_n);
        line_end = grp_end && (pos_next == r_len);

        o_in_ready      = (r_state == uule_pkg::S_IDLE);
        o_buf_req.we    = 1'b0;
        o_buf_req.waddr = r_count[uule_pkg::ADDR_W-1:0];
        o_buf_req.wdata = i_in_byte;
        o_buf_req.raddr = uule_pkg::ADDR_W'(CW'(r_pos + CW'(r_k)));

        unique case (r_state)
            uule_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_buf_req.we = 1'b1;
                    if (full || i_in_last) begin
                        n_len   = cnt_inc;
                        n_term  = full && i_in_last;
                        n_pos   = '0;
                        n_count = '0;
                        n_state = uule_pkg::S_LEN;
                    end else begin
                        n_count = cnt_inc;
                    end
                end
            end
            uule_pkg::S_LEN: begin
                if (out_free) begin
                    n_out.out_char    = 8'(r_len) + r_offset;
                    n_out.end_of_line = 1'b0;
                    n_out.last_of_run = 1'b0;
                    n_ovalid          = 1'b1;
                    n_k               = '0;
                    n_word            = '0;
                    n_state           = uule_pkg::S_RD;
                end
            end
            uule_pkg::S_RD: begin
                n_state = uule_pkg::S_CAP;
            end
            uule_pkg::S_CAP: begin
                case (r_k)
                    2'd0:    n_word[23:16] = i_buf_rdata;
                    2'd1:    n_word[15:8]  = i_buf_rdata;
                    default: n_word[7:0]   = i_buf_rdata;
                endcase
                if (2'(r_k + 2'd1) == grp_n) begin
                    n_c     = '0;
                    n_state = uule_pkg::S_CHR;
                end else begin
                    n_k     = 2'(r_k + 2'd1);
                    n_state = uule_pkg::S_RD;
                end
            end
            uule_pkg::S_CHR: begin
                if (out_free) begin
                    n_out.out_char    = {2'b00, r_word[23:18]} + r_offset;
                    n_out.end_of_line = line_end;
                    n_out.last_of_run = line_end && !r_term;
                    n_ovalid          = 1'b1;
                    n_word            = {r_word[17:0], 6'd0};
                    n_c               = 2'(r_c + 2'd1);
                    if (grp_end) begin
                        n_pos  = pos_next;
                        n_k    = '0;
                        n_word = '0;
                        if (line_end) begin
                            n_state = r_term ? uule_pkg::S_TERM : uule_pkg::S_IDLE;
                        end else begin
                            n_state = uule_pkg::S_RD;
                        end
                    end
                end
            end
            uule_pkg::S_TERM: begin
                if (out_free) begin
                    n_out.out_char    = r_offset;
                    n_out.end_of_line = 1'b1;
                    n_out.last_of_run = 1'b1;
                    n_ovalid          = 1'b1;
                    n_state           = uule_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = uule_pkg::S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_ovalid;
    assign o_out_item  = r_out;

endmodule

// ----- hw/rtl/uule_checker.sv -----
// Port-level checker for the uuencode line encoder, bound to the top level
`timescale 1ns / 1ps
`include "uuencode_line_encoder_unit_macros.svh"
module uule_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast,
    input logic [0:0] m_axis_tuser
);

    `UULE_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled item changed")
    `UULE_ASSERT_IMP(a_run_eol, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[0], m_axis_tlast, "last of run without end of line")
    `UULE_ASSERT_IMP(a_busy_after_accept, i_clk, i_rst_n, $fell(s_axis_tready), $past(s_axis_tvalid), "ready dropped without an accepted item")
    `UULE_ASSERT_IMP(a_ready_after_run, i_clk, i_rst_n, $rose(s_axis_tready), m_axis_tvalid && m_axis_tuser[0], "ready back before the last result")

endmodule

bind uuencode_line_encoder_unit uule_checker u_uule_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

// ----- dv/uuencode_line_encoder_unit_test.sv -----
// Self-checking testbench for the uuencode line encoder: directed table plus random byte streams
`timescale 1ns / 1ps
module uuencode_line_encoder_unit_test;

    typedef struct packed {
        logic [7:0] data;
        logic       eod;
        logic       has_typed;
        logic [7:0] len_char;
        logic [7:0] char0;
        logic [7:0] char1;
    } t_stim_row;

    // typed rows are one-byte lines at the reset offset of 32
    t_stim_row directed_rows [18] = '{
        '{8'h00, 1'b1, 1'b1, 8'd33, 8'd32, 8'd32},
        '{8'hFF, 1'b1, 1'b1, 8'd33, 8'd95, 8'd80},
        '{8'h03, 1'b1, 1'b1, 8'd33, 8'd32, 8'd80},
        '{8'hFC, 1'b1, 1'b1, 8'd33, 8'd95, 8'd32},
        '{8'h80, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0},
        '{8'h01, 1'b1, 1'b0, 8'd0, 8'd0, 8'd0},
        '{8'h12, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0},
        '{8'h34, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0},
        '{8'h56, 1'b1, 1'b0, 8'd0, 8'd0, 8'd0},
        '{8'hDE, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0},
        '{8'hAD, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0},
        '{8'hBE, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0},
        '{8'hEF, 1'b1, 1'b0, 8'd0, 8'd0, 8'd0},
        '{8'h55, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0},
        '{8'hAA, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0},
        '{8'h0F, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0},
        '{8'hF0, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0},
        '{8'hC3, 1'b1, 1'b0, 8'd0, 8'd0, 8'd0}
    };

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [7:0] i_cfg_wdata = 8'd0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'd0;   // [7:0] data_byte
    logic       s_axis_tlast = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;          // [7:0] out_char
    logic       m_axis_tlast;
    logic [0:0] m_axis_tuser;          // [0] last_of_run

    uuencode_line_encoder_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 i_clk = ~i_clk;

    // encoder model state
    logic [7:0] line_buf [uule_pkg::LINE_BYTES];
    int         line_fill = 0;
    logic [7:0] char_offset_q = uule_pkg::CHAR_OFFSET_RST;

    uule_pkg::t_out_item expected_chars [$];
    int         error_count = 0;
    int         send_idle_pct = 37;
    int         recv_idle_pct = 37;
    int         hold_requests = 0;
    int         holds_taken = 0;
    int         hold_left = 0;

    function automatic void encode_line(input int len, ref uule_pkg::t_out_item res [$]);
        logic [23:0]         word;
        logic [5:0]          code;
        uule_pkg::t_out_item item;
        int                  n;
        item.out_char    = 8'(len) + char_offset_q;
        item.end_of_line = (len == 0);
        item.last_of_run = 1'b0;
        res.push_back(item);
        for (int pos = 0; pos < len; pos += 3) begin
            n = (len - pos > 3) ? 3 : len - pos;
            word = {line_buf[pos],
                    (n > 1) ? line_buf[pos + 1] : 8'h00,
                    (n > 2) ? line_buf[pos + 2] : 8'h00};
            for (int c = 0; c <= n; c++) begin
                code = word[23 - 6 * c -: 6];
                item.out_char    = {2'b00, code} + char_offset_q;
                item.end_of_line = (pos + n == len) && (c == n);
                item.last_of_run = 1'b0;
                res.push_back(item);
            end
        end
    endfunction

    function automatic void predict_byte(input logic [7:0] b, input logic eod,
                                         ref uule_pkg::t_out_item res [$]);
        logic                full;
        uule_pkg::t_out_item tail;
        if (line_fill >= uule_pkg::LINE_BYTES) line_fill = 0;
        line_buf[line_fill] = b;
        line_fill++;
        full = (line_fill == uule_pkg::LINE_BYTES);
        if (full || eod) begin
            encode_line(line_fill, res);
            if (full && eod) encode_line(0, res);
            line_fill = 0;
            tail = res.pop_back();
            tail.last_of_run = 1'b1;
            res.push_back(tail);
        end
    endfunction

    task automatic send_byte(input t_stim_row row);
        uule_pkg::t_out_item fresh [$];
        uule_pkg::t_out_item item;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= row.data;
        s_axis_tlast  <= row.eod;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_byte(row.data, row.eod, fresh);
        if (row.has_typed) begin
            item = '{row.len_char, 1'b0, 1'b0};
            expected_chars.push_back(item);
            item = '{row.char0, 1'b0, 1'b0};
            expected_chars.push_back(item);
            item = '{row.char1, 1'b1, 1'b1};
            expected_chars.push_back(item);
        end else begin
            foreach (fresh[i]) expected_chars.push_back(fresh[i]);
        end
    endtask

    task automatic send_stream(inout int items);
        t_stim_row row;
        int        len;
        int        pick;
        pick = $urandom_range(0, 9);
        if (pick < 6)       len = $urandom_range(1, uule_pkg::LINE_BYTES - 1);
        else if (pick < 8)  len = uule_pkg::LINE_BYTES;
        else if (pick == 8) len = 2 * uule_pkg::LINE_BYTES;
        else                len = $urandom_range(uule_pkg::LINE_BYTES + 1, 100);
        for (int i = 0; i < len; i++) begin
            row = '0;
            row.data = 8'($urandom_range(0, 255));
            row.eod  = (i == len - 1);
            send_byte(row);
        end
        items += len;
    endtask

    task automatic drain_and_write_offset(input logic [7:0] value);
        s_axis_tvalid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we      <= 1'b0;
        char_offset_q  = value;
    endtask

    always @(posedge i_clk) begin
        if (hold_requests != holds_taken) begin
            holds_taken   <= hold_requests;
            hold_left     <= 400;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        uule_pkg::t_out_item want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_chars.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected char %02h eol %0b lor %0b",
                             m_axis_tdata, m_axis_tlast, m_axis_tuser[0]);
            end else begin
                want = expected_chars.pop_front();
                if (want.out_char !== m_axis_tdata || want.end_of_line !== m_axis_tlast
                        || want.last_of_run !== m_axis_tuser[0]) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("mismatch: exp %02h/%0b/%0b got %02h/%0b/%0b",
                                 want.out_char, want.end_of_line, want.last_of_run,
                                 m_axis_tdata, m_axis_tlast, m_axis_tuser[0]);
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        int items;
        recv_idle_pct <= 85;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) send_byte(directed_rows[i]);

        drain_and_write_offset(8'd0);
        items = 0;
        while (items < 60) send_stream(items);

        drain_and_write_offset(8'd255);
        send_idle_pct = 85;
        recv_idle_pct <= 37;
        items = 0;
        while (items < 60) send_stream(items);

        drain_and_write_offset(8'($urandom_range(1, 254)));
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        hold_requests <= hold_requests + 1;
        items = 0;
        while (items < 60) send_stream(items);

        s_axis_tvalid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
